// ----- rtl/k_way_sorted_list_merge_unit_defines.svh -----
// Assertion macros for the checker file.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef K_WAY_SORTED_LIST_MERGE_UNIT_DEFINES_SVH
`define K_WAY_SORTED_LIST_MERGE_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define KWM_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define KWM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/kwm_pkg.sv -----
`default_nettype none

package kwm_pkg;

    localparam int DATA_W           = 32;
    localparam int DEF_MAX_ELEMENTS = 64;
    localparam int DEF_MAX_LISTS    = 16;

    typedef logic signed [DATA_W-1:0] data_t;

endpackage

`default_nettype wire

// ----- rtl/kwm_item_if.sv -----
`default_nettype none

interface kwm_item_if
    import kwm_pkg::*;
();

    logic  valid;
    logic  ready;
    data_t value;
    logic  end_of_list;
    logic  end_of_set;

    modport source (output valid, output value, output end_of_list, output end_of_set,
                    input ready);
    modport sink   (input valid, input value, input end_of_list, input end_of_set,
                    output ready);

endinterface

`default_nettype wire

// ----- rtl/kwm_result_if.sv -----
`default_nettype none

interface kwm_result_if
    import kwm_pkg::*;
();

    logic  valid;
    logic  ready;
    data_t merged_value;
    logic  last_out;
    logic  overflow;

    modport source (output valid, output merged_value, output last_out, output overflow,
                    input ready);
    modport sink   (input valid, input merged_value, input last_out, input overflow,
                    output ready);

endinterface

`default_nettype wire

// ----- rtl/kwm_elem_mem.sv -----
`default_nettype none

module kwm_elem_mem
    import kwm_pkg::*;
#(
    parameter int DEPTH = DEF_MAX_ELEMENTS,
    parameter int AW    = $clog2(DEPTH)
)
(
    input  wire logic          clk,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire data_t         wr_data,
    input  wire logic [AW-1:0] rd_addr,
    output data_t              rd_data
);

    data_t mem_reg [DEPTH];
    data_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ----- rtl/kwm_list_mem.sv -----
`default_nettype none

module kwm_list_mem
    import kwm_pkg::*;
#(
    parameter int NLISTS = DEF_MAX_LISTS,
    parameter int CW     = $clog2(DEF_MAX_ELEMENTS + 1),
    parameter int LW     = $clog2(NLISTS)
)
(
    input  wire logic          clk,
    input  wire logic          end_we,
    input  wire logic          pos_we,
    input  wire logic [LW-1:0] wr_idx,
    input  wire logic [CW-1:0] end_wdata,
    input  wire logic [CW-1:0] pos_wdata,
    input  wire logic [LW-1:0] rd_idx,
    output logic      [CW-1:0] end_rdata,
    output logic      [CW-1:0] pos_rdata
);

    // End offset and read position of every closed list.
    logic [CW-1:0] end_mem_reg [NLISTS];
    logic [CW-1:0] pos_mem_reg [NLISTS];
    logic [CW-1:0] end_rd_reg;
    logic [CW-1:0] pos_rd_reg;

    always_ff @(posedge clk)
    begin
        if (end_we)
        begin
            end_mem_reg[wr_idx] <= end_wdata;
        end
        if (pos_we)
        begin
            pos_mem_reg[wr_idx] <= pos_wdata;
        end
        end_rd_reg <= end_mem_reg[rd_idx];
        pos_rd_reg <= pos_mem_reg[rd_idx];
    end

    assign end_rdata = end_rd_reg;
    assign pos_rdata = pos_rd_reg;

endmodule

`default_nettype wire

// ----- rtl/kwm_min_unit.sv -----
`default_nettype none

module kwm_min_unit
    import kwm_pkg::*;
#(
    parameter int LW = $clog2(DEF_MAX_LISTS),
    parameter int CW = $clog2(DEF_MAX_ELEMENTS + 1)
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          clear,
    input  wire logic          cand_vld,
    input  wire data_t         cand_val,
    input  wire logic [LW-1:0] cand_idx,
    input  wire logic [CW-1:0] cand_pos,
    output logic               found,
    output data_t              best_val,
    output logic      [LW-1:0] best_idx,
    output logic      [CW-1:0] best_pos
);

    logic          found_reg;
    data_t         best_val_reg;
    logic [LW-1:0] best_idx_reg;
    logic [CW-1:0] best_pos_reg;
    logic          take;

    // The single signed comparator that every list head passes through.
    assign take = cand_vld && (!found_reg || (cand_val < best_val_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b0;
        end
        else if (clear)
        begin
            found_reg <= 1'b0;
        end
        else if (take)
        begin
            found_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            best_val_reg <= cand_val;
            best_idx_reg <= cand_idx;
            best_pos_reg <= cand_pos;
        end
    end

    assign found    = found_reg;
    assign best_val = best_val_reg;
    assign best_idx = best_idx_reg;
    assign best_pos = best_pos_reg;

endmodule

`default_nettype wire

// ----- rtl/k_way_sorted_list_merge_unit.sv -----
// K-way merge of ascending lists of signed 32-bit values.
// The items channel takes one list element per beat, marked with end_of_list on the last
// element of a list and end_of_set on the last element of the whole set. Loading beats are
// taken one per cycle while the block is loading.
// The beat that carries end_of_set starts the merge; the block then drops ready and sends
// every stored value on the merged channel in ascending order, last_out marking the final
// beat and overflow set on every beat of a set in which elements or lists were dropped.
// Each result costs one pass of a single comparator over all closed lists; a pass starts
// once the previous result has been taken, or after the end_of_set beat.
// A set with no stored elements gives no results and the block is ready again at once.
// When the receiver stalls, the current result is held in the output register and the
// search for the next one waits until it has been taken.
// Reset empties the block; the stores need no clearing since only entries written during
// the current set are read. Ready is high from the first cycle after reset.
`default_nettype none

module k_way_sorted_list_merge_unit
    import kwm_pkg::*;
#(
    parameter int MAX_ELEMENTS = DEF_MAX_ELEMENTS,
    parameter int MAX_LISTS    = DEF_MAX_LISTS
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    kwm_item_if.sink      items,
    kwm_result_if.source  merged
);

    localparam int AW  = $clog2(MAX_ELEMENTS);
    localparam int CW  = $clog2(MAX_ELEMENTS + 1);
    localparam int LW  = $clog2(MAX_LISTS);
    localparam int LCW = $clog2(MAX_LISTS + 1);

    localparam logic [1:0] ST_LOAD = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [1:0]     state_reg, state_next;
    logic [CW-1:0]  ec_reg, ec_next;
    logic [LCW-1:0] lc_reg, lc_next;
    logic [CW-1:0]  last_end_reg, last_end_next;
    logic           dropped_reg, dropped_next;
    logic [LCW-1:0] i_reg, i_next;
    logic [CW-1:0]  n_reg, n_next;
    logic           s1_vld_reg;
    logic [LW-1:0]  s1_idx_reg;
    logic           s2_vld_reg;
    logic [LW-1:0]  s2_idx_reg;
    logic [CW-1:0]  s2_pos_reg;
    logic           out_vld_reg, out_vld_next;
    data_t          out_val_reg;
    logic           out_last_reg;
    logic           out_ovf_reg;
    logic           load_out;

    logic           accept;
    logic           room;
    logic           lists_free;
    logic [CW-1:0]  ec_after;
    logic           do_close;
    logic           issue;
    logic           cand_ok;
    logic           scan_done;
    logic           out_take;
    logic           adv_we;

    logic [CW-1:0]  end_rdata;
    logic [CW-1:0]  pos_rdata;
    data_t          elem_rdata;
    logic           found;
    data_t          best_val;
    logic [LW-1:0]  best_idx;
    logic [CW-1:0]  best_pos;

    assign items.ready = (state_reg == ST_LOAD);
    assign accept      = items.valid && items.ready;

    assign lists_free = (lc_reg < LCW'(MAX_LISTS));
    assign room       = lists_free && (ec_reg < CW'(MAX_ELEMENTS));
    assign ec_after   = room ? CW'(ec_reg + 1'b1) : ec_reg;
    assign do_close   = lists_free &&
                        (items.end_of_list || (items.end_of_set && (ec_after > last_end_reg)));

    assign issue     = (state_reg == ST_SCAN) && (i_reg < lc_reg);
    assign cand_ok   = s1_vld_reg && (pos_rdata < end_rdata);
    assign scan_done = (state_reg == ST_SCAN) && (i_reg == lc_reg) && !s1_vld_reg
                       && !s2_vld_reg;
    assign adv_we    = scan_done && found;
    assign out_take  = out_vld_reg && merged.ready;

    kwm_elem_mem #(
        .DEPTH (MAX_ELEMENTS),
        .AW    (AW)
    ) u_elem_mem (
        .clk     (clk),
        .wr_en   (accept && room),
        .wr_addr (ec_reg[AW-1:0]),
        .wr_data (items.value),
        .rd_addr (pos_rdata[AW-1:0]),
        .rd_data (elem_rdata)
    );

    kwm_list_mem #(
        .NLISTS (MAX_LISTS),
        .CW     (CW),
        .LW     (LW)
    ) u_list_mem (
        .clk       (clk),
        .end_we    (accept && do_close),
        .pos_we    ((accept && do_close) || adv_we),
        .wr_idx    (adv_we ? best_idx : lc_reg[LW-1:0]),
        .end_wdata (ec_after),
        .pos_wdata (adv_we ? CW'(best_pos + 1'b1) : last_end_reg),
        .rd_idx    (i_reg[LW-1:0]),
        .end_rdata (end_rdata),
        .pos_rdata (pos_rdata)
    );

    kwm_min_unit #(
        .LW (LW),
        .CW (CW)
    ) u_min_unit (
        .clk      (clk),
        .rst_n    (rst_n),
        .clear    (state_reg != ST_SCAN),
        .cand_vld (s2_vld_reg),
        .cand_val (elem_rdata),
        .cand_idx (s2_idx_reg),
        .cand_pos (s2_pos_reg),
        .found    (found),
        .best_val (best_val),
        .best_idx (best_idx),
        .best_pos (best_pos)
    );

    always_comb
    begin
        state_next    = state_reg;
        ec_next       = ec_reg;
        lc_next       = lc_reg;
        last_end_next = last_end_reg;
        dropped_next  = dropped_reg;
        i_next        = i_reg;
        n_next        = n_reg;
        out_vld_next  = out_vld_reg;
        load_out      = 1'b0;

        case (state_reg)
            ST_LOAD:
            begin
                if (accept)
                begin
                    ec_next = ec_after;
                    if (!room)
                    begin
                        dropped_next = 1'b1;
                    end
                    if (do_close)
                    begin
                        lc_next       = LCW'(lc_reg + 1'b1);
                        last_end_next = ec_after;
                    end
                    if (items.end_of_set)
                    begin
                        i_next = '0;
                        n_next = '0;
                        if (ec_after == '0)
                        begin
                            ec_next       = '0;
                            lc_next       = '0;
                            last_end_next = '0;
                            dropped_next  = 1'b0;
                        end
                        else
                        begin
                            state_next = ST_SCAN;
                        end
                    end
                end
            end
            ST_SCAN:
            begin
                if (issue)
                begin
                    i_next = LCW'(i_reg + 1'b1);
                end
                if (scan_done)
                begin
                    if (found)
                    begin
                        out_vld_next = 1'b1;
                        load_out     = 1'b1;
                        state_next   = ST_EMIT;
                    end
                    else
                    begin
                        ec_next       = '0;
                        lc_next       = '0;
                        last_end_next = '0;
                        dropped_next  = 1'b0;
                        state_next    = ST_LOAD;
                    end
                end
            end
            ST_EMIT:
            begin
                if (out_take)
                begin
                    out_vld_next = 1'b0;
                    if (out_last_reg)
                    begin
                        ec_next       = '0;
                        lc_next       = '0;
                        last_end_next = '0;
                        dropped_next  = 1'b0;
                        state_next    = ST_LOAD;
                    end
                    else
                    begin
                        n_next     = CW'(n_reg + 1'b1);
                        i_next     = '0;
                        state_next = ST_SCAN;
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_LOAD;
            ec_reg       <= '0;
            lc_reg       <= '0;
            last_end_reg <= '0;
            dropped_reg  <= 1'b0;
            i_reg        <= '0;
            n_reg        <= '0;
            s1_vld_reg   <= 1'b0;
            s2_vld_reg   <= 1'b0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            ec_reg       <= ec_next;
            lc_reg       <= lc_next;
            last_end_reg <= last_end_next;
            dropped_reg  <= dropped_next;
            i_reg        <= i_next;
            n_reg        <= n_next;
            s1_vld_reg   <= issue;
            s2_vld_reg   <= cand_ok;
            out_vld_reg  <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_idx_reg <= i_reg[LW-1:0];
        s2_idx_reg <= s1_idx_reg;
        s2_pos_reg <= pos_rdata;
        if (load_out)
        begin
            out_val_reg  <= best_val;
            out_last_reg <= (n_reg == CW'(ec_reg - 1'b1));
            out_ovf_reg  <= dropped_reg;
        end
    end

    assign merged.valid        = out_vld_reg;
    assign merged.merged_value = out_val_reg;
    assign merged.last_out     = out_last_reg;
    assign merged.overflow     = out_ovf_reg;

endmodule

`default_nettype wire

// ----- rtl/kwm_checker.sv -----
`default_nettype none
`include "k_way_sorted_list_merge_unit_defines.svh"

module kwm_checker
    import kwm_pkg::*;
(
    input wire logic  clk,
    input wire logic  rst_n,
    input wire logic  in_valid,
    input wire logic  in_ready,
    input wire logic  in_eos,
    input wire logic  out_valid,
    input wire logic  out_ready,
    input wire data_t out_value,
    input wire logic  out_last,
    input wire logic  out_ovf
);

    `KWM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_value) && $stable(out_last) && $stable(out_ovf), "stalled result beat changed")
    `KWM_ASSERT_SAME(a_no_load_while_emit, out_valid, !in_ready, "items taken while a result is pending")
    `KWM_ASSERT_NEXT(a_quiet_between_sets, in_valid && in_ready && !in_eos, !out_valid, "result offered after a beat without end_of_set")
    `KWM_ASSERT_NEXT(a_ready_after_last, out_valid && out_ready && out_last, in_ready && !out_valid, "block not ready after the final result")

endmodule

bind k_way_sorted_list_merge_unit kwm_checker u_kwm_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (items.valid),
    .in_ready  (items.ready),
    .in_eos    (items.end_of_set),
    .out_valid (merged.valid),
    .out_ready (merged.ready),
    .out_value (merged.merged_value),
    .out_last  (merged.last_out),
    .out_ovf   (merged.overflow)
);

`default_nettype wire

// ----- sim/tb.sv -----
`timescale 1ns / 100ps

module tb;
    import kwm_pkg::*;

    localparam int MAX_ELEM   = DEF_MAX_ELEMENTS;
    localparam int MAX_LIST   = DEF_MAX_LISTS;
    localparam int CYCLE_CAP  = 600000;
    localparam int TAIL_WAIT  = 200;
    localparam int PHASE_ITEMS = 75;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        data_t value;
        logic  last;
        logic  ovf;
    } merge_result_t;

    typedef struct {
        data_t value;
        bit    eol;
        bit    eos;
    } load_beat_t;

    class merge_scoreboard;
        data_t         store[MAX_ELEM];
        int            list_end[MAX_LIST];
        int            read_pos[MAX_LIST];
        int            n_elem;
        int            n_lists;
        bit            dropped;
        merge_result_t expected_q[$];
        int            errors;

        function new();
            errors = 0;
            clear_set();
        endfunction

        function void clear_set();
            n_elem  = 0;
            n_lists = 0;
            dropped = 0;
        endfunction

        function int list_base(int idx);
            return (idx == 0) ? 0 : list_end[idx - 1];
        endfunction

        function void close_list();
            if (n_lists < MAX_LIST)
            begin
                list_end[n_lists] = n_elem;
                n_lists++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void note_item(data_t v, bit eol, bit eos);
            if (n_lists < MAX_LIST && n_elem < MAX_ELEM)
            begin
                store[n_elem] = v;
                n_elem++;
            end
            else
            begin
                dropped = 1'b1;
            end
            if (eol)
                close_list();
            else if (eos && n_lists < MAX_LIST && n_elem > list_base(n_lists))
                close_list();
            if (eos)
                merge_set();
        endfunction

        function void merge_set();
            int            best;
            data_t         best_v;
            bit            found;
            bit            have_prev;
            int            produced;
            merge_result_t prev;
            best      = 0;
            best_v    = '0;
            have_prev = 1'b0;
            produced  = 0;
            prev      = '0;
            for (int i = 0; i < n_lists; i++)
                read_pos[i] = list_base(i);
            while (produced < n_elem)
            begin
                found = 1'b0;
                for (int i = 0; i < n_lists; i++)
                begin
                    if (read_pos[i] < list_end[i] && read_pos[i] < MAX_ELEM)
                    begin
                        if (!found || store[read_pos[i]] < best_v)
                        begin
                            found  = 1'b1;
                            best   = i;
                            best_v = store[read_pos[i]];
                        end
                    end
                end
                if (!found)
                    break;
                read_pos[best]++;
                if (have_prev)
                    expected_q = {expected_q, prev};
                prev.value = best_v;
                prev.last  = 1'b0;
                prev.ovf   = dropped;
                have_prev  = 1'b1;
                produced++;
            end
            if (have_prev)
            begin
                prev.last = 1'b1;
                expected_q = {expected_q, prev};
            end
            clear_set();
        endfunction

        function void check_result(data_t v, logic l, logic o);
            merge_result_t want;
            if (expected_q.size() == 0)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("Unexpected result beat: value %0d last %b overflow %b", v, l, o);
            end
            else
            begin
                want = expected_q.pop_front();
                if (v !== want.value || l !== want.last || o !== want.ovf)
                begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $display("Mismatch: want %0d last %b ovf %b, got %0d last %b ovf %b",
                                 want.value, want.last, want.ovf, v, l, o);
                end
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    int   send_idle_pct;
    int   recv_stall_pct;
    int   items_sent;
    int   cycle_count;

    merge_scoreboard sb = new();
    load_beat_t      beat_q[$];

    kwm_item_if   items_ch ();
    kwm_result_if merged_ch ();

    k_way_sorted_list_merge_unit uut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .items  (items_ch),
        .merged (merged_ch)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        merged_ch.ready = 1'b0;
    end

    always @(posedge clk)
    begin
        merged_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && merged_ch.valid && merged_ch.ready)
            sb.check_result(merged_ch.merged_value, merged_ch.last_out, merged_ch.overflow);
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_CAP)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    function automatic int pick_value(int vmode);
        int v;
        v = 0;
        case (vmode)
            0: v = $urandom;
            1: v = int'($urandom_range(6)) - 3;
            default:
            begin
                case ($urandom_range(6))
                    0: v = 32'h8000_0000;
                    1: v = 32'h8000_0001;
                    2: v = -1;
                    3: v = 0;
                    4: v = 1;
                    5: v = 32'h7fff_fffe;
                    default: v = 32'h7fff_ffff;
                endcase
            end
        endcase
        return v;
    endfunction

    task automatic add_beat(data_t v, bit eol, bit eos);
        load_beat_t b;
        b.value = v;
        b.eol   = eol;
        b.eos   = eos;
        beat_q  = {beat_q, b};
    endtask

    task automatic add_list(int len, int vmode, bit sorted, bit ends_set);
        int  vals[$];
        bit  is_last;
        for (int i = 0; i < len; i++)
            vals = {vals, pick_value(vmode)};
        if (sorted)
            vals.sort();
        for (int i = 0; i < len; i++)
        begin
            is_last = (i == len - 1);
            add_beat(vals[i], is_last ? (ends_set ? bit'($urandom_range(1)) : 1'b1) : 1'b0,
                     is_last && ends_set);
        end
    endtask

    task automatic send_item(data_t v, bit eol, bit eos);
        while ($urandom_range(99) < send_idle_pct)
        begin
            items_ch.valid <= 1'b0;
            @(posedge clk);
        end
        items_ch.valid       <= 1'b1;
        items_ch.value       <= v;
        items_ch.end_of_list <= eol;
        items_ch.end_of_set  <= eos;
        @(posedge clk);
        while (!items_ch.ready)
            @(posedge clk);
        sb.note_item(v, eol, eos);
        items_sent++;
    endtask

    task automatic send_beats();
        load_beat_t b;
        while (beat_q.size() != 0)
        begin
            b = beat_q.pop_front();
            send_item(b.value, b.eol, b.eos);
        end
    endtask

    task automatic pause_until_drained();
        items_ch.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    task automatic build_random_set();
        int kind;
        int nl;
        int remaining;
        int len;
        int n;
        kind = $urandom_range(99);
        if (kind < 8)
        begin
            // Up to 72 elements, often enough to fill the store; lists lying wholly past it end up empty.
            remaining = $urandom_range(60, 72);
            while (remaining > 0)
            begin
                len = $urandom_range(1, (remaining < 20) ? remaining : 20);
                remaining -= len;
                add_list(len, $urandom_range(2), 1'b1, remaining == 0);
            end
        end
        else if (kind < 16)
        begin
            nl = $urandom_range(15, 20);
            for (int i = 0; i < nl; i++)
                add_list($urandom_range(1, 3), $urandom_range(2), 1'b1, i == nl - 1);
        end
        else if (kind < 28)
        begin
            n = $urandom_range(1, 10);
            for (int i = 0; i < n; i++)
                add_beat($urandom, $urandom_range(9) < 3, i == n - 1);
        end
        else
        begin
            nl = $urandom_range(1, 6);
            for (int i = 0; i < nl; i++)
                add_list($urandom_range(1, 8), $urandom_range(2), 1'b1, i == nl - 1);
        end
    endtask

    initial
    begin
        int idle_tab[4];
        int stall_tab[4];
        int target;
        idle_tab  = '{0, 61, 0, 33};
        stall_tab = '{0, 0, 61, 33};
        cycle_count          = 0;
        items_sent           = 0;
        send_idle_pct        = 0;
        recv_stall_pct       = 0;
        rst_n                = 1'b0;
        items_ch.valid       = 1'b0;
        items_ch.value       = '0;
        items_ch.end_of_list = 1'b0;
        items_ch.end_of_set  = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Two one-beat sets: one closed by its list mark, one whose list is left open.
        add_beat(32'sd0, 1'b1, 1'b1);
        add_beat(32'h7fff_ffff, 1'b0, 1'b1);
        // Ties at both extremes across two lists, the second still open when the set ends.
        add_beat(32'h8000_0000, 1'b0, 1'b0);
        add_beat(-32'sd1, 1'b0, 1'b0);
        add_beat(32'h7fff_ffff, 1'b1, 1'b0);
        add_beat(32'h8000_0000, 1'b0, 1'b0);
        add_beat(32'sd0, 1'b0, 1'b0);
        add_beat(32'h7fff_ffff, 1'b0, 1'b1);
        // Alternating bit patterns and repeated values over three lists.
        add_beat(32'haaaa_aaaa, 1'b1, 1'b0);
        add_beat(32'h5555_5554, 1'b0, 1'b0);
        add_beat(32'h5555_5555, 1'b1, 1'b0);
        add_beat(32'sd2, 1'b0, 1'b0);
        add_beat(32'sd2, 1'b0, 1'b0);
        add_beat(32'sd2, 1'b1, 1'b1);
        send_beats();
        pause_until_drained();

        for (int ph = 0; ph < 4; ph++)
        begin
            send_idle_pct  = idle_tab[ph];
            recv_stall_pct = stall_tab[ph];
            target = items_sent + PHASE_ITEMS;
            while (items_sent < target)
            begin
                build_random_set();
                send_beats();
            end
            pause_until_drained();
        end

        repeat (TAIL_WAIT) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
